// File: hdl/drblt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drblt_pkg
// Request codes, register indexes, configuration struct and tune tables of
// the door relay, buzzer and LED timer unit.
// ----------------------------------------------------------------------------
package drblt_pkg;

	localparam int REQ_W   = 3;
	localparam int DUR_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;
	localparam int TUNE_W  = 10;

	localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_OPEN    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLOSE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_BEEP    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SUCCESS = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DENIED  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_OPENMEL = 3'd6;
	localparam logic [REQ_W-1:0] REQ_BLINK   = 3'd7;

	localparam logic [CIDX_W-1:0] CFG_RELAY_DEFAULT = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_RELAY_POL     = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_SENSOR_POL    = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_SENSOR_PRES   = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_BUTTON_PRES   = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_DEBOUNCE      = 3'd5;

	localparam logic [1:0] TUNE_SINGLE  = 2'd0;
	localparam logic [1:0] TUNE_SUCCESS = 2'd1;
	localparam logic [1:0] TUNE_DENIED  = 2'd2;
	localparam logic [1:0] TUNE_OPEN    = 2'd3;

	localparam logic [TUNE_W-1:0] BEEP_DEFAULT_MS = 10'd200;

	typedef struct packed {
		logic [DUR_W-1:0] relay_default_ms;
		logic             relay_polarity_low;
		logic             sensor_polarity_low;
		logic             sensor_present;
		logic             button_present;
		logic [DUR_W-1:0] debounce_window_ms;
	} cfg_t;

	function automatic logic [TUNE_W-1:0] tune_on_ms(input logic [1:0] sel,
			input logic [1:0] s);
		logic [TUNE_W-1:0] r;
		begin
			unique case ({sel, s})
				{TUNE_SINGLE, 2'd0}:  r = BEEP_DEFAULT_MS;
				{TUNE_SUCCESS, 2'd0}: r = 10'd120;
				{TUNE_SUCCESS, 2'd1}: r = 10'd120;
				{TUNE_DENIED, 2'd0}:  r = 10'd90;
				{TUNE_DENIED, 2'd1}:  r = 10'd90;
				{TUNE_DENIED, 2'd2}:  r = 10'd90;
				{TUNE_OPEN, 2'd0}:    r = 10'd400;
				default:              r = '0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [TUNE_W-1:0] tune_off_ms(input logic [1:0] sel,
			input logic [1:0] s);
		logic [TUNE_W-1:0] r;
		begin
			unique case ({sel, s})
				{TUNE_SUCCESS, 2'd0}: r = 10'd80;
				{TUNE_DENIED, 2'd0}:  r = 10'd70;
				{TUNE_DENIED, 2'd1}:  r = 10'd70;
				default:              r = '0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [1:0] tune_len(input logic [1:0] sel);
		logic [1:0] r;
		begin
			unique case (sel)
				TUNE_SINGLE:  r = 2'd1;
				TUNE_SUCCESS: r = 2'd2;
				TUNE_DENIED:  r = 2'd3;
				TUNE_OPEN:    r = 2'd1;
				default:      r = 2'd1;
			endcase
			return r;
		end
	endfunction

endpackage

// File: hdl/drblt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drblt request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface drblt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [15:0] duration_ms;
	logic        button_pressed;
	logic        sensor_level;

	modport source (output valid, output req_type, output duration_ms,
		output button_pressed, output sensor_level, input ready);
	modport sink (input valid, input req_type, input duration_ms,
		input button_pressed, input sensor_level, output ready);
endinterface

interface drblt_res_if;
	logic valid;
	logic ready;
	logic relay_level;
	logic buzzer_level;
	logic led_level;
	logic door_unlocked;
	logic door_physically_open;
	logic melody_busy;

	modport source (output valid, output relay_level, output buzzer_level,
		output led_level, output door_unlocked, output door_physically_open,
		output melody_busy, input ready);
	modport sink (input valid, input relay_level, input buzzer_level,
		input led_level, input door_unlocked, input door_physically_open,
		input melody_busy, output ready);
endinterface

// File: hdl/drblt_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drblt_debounce
// Exit-button debouncer; flags one qualified press per held press.
// ----------------------------------------------------------------------------
module drblt_debounce import drblt_pkg::*; #(
	parameter int TIME_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick,
	input  logic       pressed,
	input  cfg_t       cfg,
	output logic       fire
);

	localparam logic [TIME_BITS-1:0] TMAX = '1;

	logic                 last_q;
	logic                 latched_q;
	logic [TIME_BITS-1:0] stable_q;
	logic                 last_d;
	logic                 latched_d;
	logic [TIME_BITS-1:0] stable_d;

	always_comb begin
		last_d    = last_q;
		latched_d = latched_q;
		stable_d  = stable_q;
		fire      = 1'b0;
		if (cfg.button_present) begin
			if (pressed != last_q) begin
				last_d   = pressed;
				stable_d = '0;
			end else begin
				if (stable_q != TMAX)
					stable_d = stable_q + 1'b1;
				if (pressed && (32'(stable_d) >= 32'(cfg.debounce_window_ms))) begin
					if (!latched_q) begin
						latched_d = 1'b1;
						fire      = 1'b1;
					end
				end else if (!pressed) begin
					latched_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			latched_q <= 1'b0;
			stable_q  <= '0;
		end else if (tick) begin
			last_q    <= last_d;
			latched_q <= latched_d;
			stable_q  <= stable_d;
		end
	end

endmodule

// File: hdl/door_relay_buzzer_led_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// door_relay_buzzer_led_timer_unit
// Door-access output controller: relay open timer, buzzer tune player,
// LED blink timer and exit-button debouncer, driven by ms ticks and commands.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the result output is not stalled
// and returns exactly one result per request, via the input register and
// then the result register. While a result waits, the input register still
// takes one request; further requests wait until the result is taken. Only
// tick requests advance the timers and sample the exit button; commands act
// at once. The user must write configuration (cfg_we/cfg_index/cfg_wdata)
// only while the unit is idle; the block does not enforce this. Indexes
// outside the register list are ignored. No start-up sweep after reset.
module door_relay_buzzer_led_timer_unit import drblt_pkg::*; #(
	parameter int TIME_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CDATA_W-1:0]  cfg_wdata,
	drblt_req_if.sink           req,
	drblt_res_if.source         res
);

	localparam int SW = TIME_BITS + 2;
	localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [TIME_BITS:0] STEP_MAX = '1;

	function automatic logic [TIME_BITS-1:0] sat_time(input logic [DUR_W-1:0] d);
		logic [31:0] w;
		begin
			w = 32'(d);
			if (w > TIME_MAX32)
				return TIME_BITS'(TIME_MAX32);
			return TIME_BITS'(w);
		end
	endfunction

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relay_default_ms    <= 16'd3000;
			cfg_q.relay_polarity_low  <= 1'b0;
			cfg_q.sensor_polarity_low <= 1'b1;
			cfg_q.sensor_present      <= 1'b1;
			cfg_q.button_present      <= 1'b1;
			cfg_q.debounce_window_ms  <= 16'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RELAY_DEFAULT: cfg_q.relay_default_ms    <= cfg_wdata;
				CFG_RELAY_POL:     cfg_q.relay_polarity_low  <= cfg_wdata[0];
				CFG_SENSOR_POL:    cfg_q.sensor_polarity_low <= cfg_wdata[0];
				CFG_SENSOR_PRES:   cfg_q.sensor_present      <= cfg_wdata[0];
				CFG_BUTTON_PRES:   cfg_q.button_present      <= cfg_wdata[0];
				CFG_DEBOUNCE:      cfg_q.debounce_window_ms  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	logic              valid_s1;
	logic [REQ_W-1:0]  req_type_s1;
	logic [DUR_W-1:0]  duration_s1;
	logic              pressed_s1;
	logic              sensor_s1;
	logic              res_valid_q;
	logic              adv;

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			duration_s1 <= req.duration_ms;
			pressed_s1  <= req.button_pressed;
			sensor_s1   <= req.sensor_level;
		end
	end

	// state
	logic                 unlocked_q, playing_q, buzzing_q, led_lit_q;
	logic [TIME_BITS-1:0] relay_left_q, single_on_q, led_left_q;
	logic [1:0]           sel_q, step_q;
	logic [TIME_BITS:0]   elapsed_q;

	logic                 unlocked_d, playing_d, buzzing_d, led_lit_d;
	logic [TIME_BITS-1:0] relay_left_d, single_on_d, led_left_d;
	logic [1:0]           sel_d, step_d;
	logic [TIME_BITS:0]   elapsed_d;

	logic                 is_tick;
	logic                 fire;
	logic [1:0]           s_idx;
	logic [1:0]           step_inc;
	logic [SW-1:0]        on_ms, off_ms;
	logic [TIME_BITS-1:0] open_ms, default_ms;
	logic                 phys_open;

	assign is_tick = (req_type_s1 == REQ_TICK);

	drblt_debounce #(
		.TIME_BITS (TIME_BITS)
	) u_debounce (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (adv && is_tick),
		.pressed (pressed_s1),
		.cfg     (cfg_q),
		.fire    (fire)
	);

	assign s_idx      = (step_q == 2'd3) ? 2'd0 : step_q;
	assign on_ms      = (sel_q == TUNE_SINGLE) ? SW'(single_on_q) : SW'(tune_on_ms(sel_q, s_idx));
	assign off_ms     = SW'(tune_off_ms(sel_q, s_idx));
	assign default_ms = sat_time(cfg_q.relay_default_ms);
	assign open_ms    = (duration_s1 != '0) ? sat_time(duration_s1) : default_ms;

	always_comb begin
		unlocked_d   = unlocked_q;
		relay_left_d = relay_left_q;
		playing_d    = playing_q;
		buzzing_d    = buzzing_q;
		sel_d        = sel_q;
		step_d       = step_q;
		elapsed_d    = elapsed_q;
		single_on_d  = single_on_q;
		led_lit_d    = led_lit_q;
		led_left_d   = led_left_q;
		step_inc     = step_q + 2'd1;
		unique case (req_type_s1)
			REQ_TICK: begin
				if (unlocked_q) begin
					if (relay_left_q != '0)
						relay_left_d = relay_left_q - 1'b1;
					if (relay_left_d == '0)
						unlocked_d = 1'b0;
				end
				if (playing_q) begin
					if (elapsed_q != STEP_MAX)
						elapsed_d = elapsed_q + 1'b1;
					buzzing_d = SW'(elapsed_d) < on_ms;
					if (SW'(elapsed_d) >= on_ms + off_ms) begin
						if (step_inc >= tune_len(sel_q)) begin
							playing_d = 1'b0;
							step_d    = 2'd0;
							sel_d     = TUNE_SINGLE;
							buzzing_d = 1'b0;
						end else begin
							step_d    = step_inc;
							elapsed_d = '0;
						end
					end
				end
				if (led_lit_q) begin
					if (led_left_q != '0)
						led_left_d = led_left_q - 1'b1;
					if (led_left_d == '0)
						led_lit_d = 1'b0;
				end
				if (fire) begin
					if (default_ms != '0) begin
						unlocked_d   = 1'b1;
						relay_left_d = default_ms;
					end
					sel_d     = TUNE_OPEN;
					step_d    = 2'd0;
					elapsed_d = '0;
					playing_d = 1'b1;
					buzzing_d = 1'b1;
				end
			end
			REQ_OPEN: begin
				if (open_ms != '0) begin
					unlocked_d   = 1'b1;
					relay_left_d = open_ms;
				end
			end
			REQ_CLOSE: begin
				unlocked_d   = 1'b0;
				relay_left_d = '0;
			end
			REQ_BEEP, REQ_SUCCESS, REQ_DENIED, REQ_OPENMEL: begin
				if (req_type_s1 == REQ_BEEP)
					single_on_d = (duration_s1 != '0) ? sat_time(duration_s1)
						: TIME_BITS'(BEEP_DEFAULT_MS);
				sel_d     = 2'(req_type_s1 - REQ_BEEP);
				step_d    = 2'd0;
				elapsed_d = '0;
				playing_d = 1'b1;
				buzzing_d = 1'b1;
			end
			REQ_BLINK: begin
				led_lit_d  = 1'b1;
				led_left_d = sat_time(duration_s1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unlocked_q   <= 1'b0;
			relay_left_q <= '0;
			playing_q    <= 1'b0;
			buzzing_q    <= 1'b0;
			sel_q        <= TUNE_SINGLE;
			step_q       <= 2'd0;
			elapsed_q    <= '0;
			single_on_q  <= TIME_BITS'(BEEP_DEFAULT_MS);
			led_lit_q    <= 1'b0;
			led_left_q   <= '0;
		end else if (adv) begin
			unlocked_q   <= unlocked_d;
			relay_left_q <= relay_left_d;
			playing_q    <= playing_d;
			buzzing_q    <= buzzing_d;
			sel_q        <= sel_d;
			step_q       <= step_d;
			elapsed_q    <= elapsed_d;
			single_on_q  <= single_on_d;
			led_lit_q    <= led_lit_d;
			led_left_q   <= led_left_d;
		end
	end

	// result register
	assign phys_open = cfg_q.sensor_present &&
		(cfg_q.sensor_polarity_low ? !sensor_s1 : sensor_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.relay_level          <= unlocked_d ^ cfg_q.relay_polarity_low;
			res.buzzer_level         <= buzzing_d;
			res.led_level            <= led_lit_d;
			res.door_unlocked        <= unlocked_d;
			res.door_physically_open <= phys_open;
			res.melody_busy          <= playing_d;
		end
	end

	assign res.valid = res_valid_q;

endmodule

// File: sim/drblt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drblt_tb_pkg
// Request and result records of the door timer bench, plus a scoreboard
// that tracks relay, tune, LED and exit-button timing per request and
// checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
package drblt_tb_pkg;
	import drblt_pkg::*;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [DUR_W-1:0] duration_ms;
		logic             button_pressed;
		logic             sensor_level;
	} door_req_t;

	typedef struct packed {
		logic relay_level;
		logic buzzer_level;
		logic led_level;
		logic door_unlocked;
		logic door_physically_open;
		logic melody_busy;
	} door_out_t;

	class door_timer_scoreboard;
		cfg_t             cfg;
		logic             unlocked;
		logic             playing;
		logic             buzzing;
		logic             led_lit;
		logic             btn_last;
		logic             btn_latched;
		logic [DUR_W-1:0] relay_left;
		logic [DUR_W-1:0] single_on_ms;
		logic [DUR_W-1:0] led_left;
		logic [DUR_W-1:0] btn_stable_ms;
		logic [1:0]       tune_sel;
		logic [1:0]       tune_step;
		logic [DUR_W:0]   step_elapsed;
		door_out_t        expected_q[$];
		int               errors;

		function new();
			cfg.relay_default_ms    = 16'd3000;
			cfg.relay_polarity_low  = 1'b0;
			cfg.sensor_polarity_low = 1'b1;
			cfg.sensor_present      = 1'b1;
			cfg.button_present      = 1'b1;
			cfg.debounce_window_ms  = 16'd50;
			unlocked      = 1'b0;
			playing       = 1'b0;
			buzzing       = 1'b0;
			led_lit       = 1'b0;
			btn_last      = 1'b0;
			btn_latched   = 1'b0;
			relay_left    = '0;
			single_on_ms  = 16'd200;
			led_left      = '0;
			btn_stable_ms = '0;
			tune_sel      = TUNE_SINGLE;
			tune_step     = 2'd0;
			step_elapsed  = '0;
			errors        = 0;
		endfunction

		function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
			case (idx)
				CFG_RELAY_DEFAULT: cfg.relay_default_ms    = data;
				CFG_RELAY_POL:     cfg.relay_polarity_low  = data[0];
				CFG_SENSOR_POL:    cfg.sensor_polarity_low = data[0];
				CFG_SENSOR_PRES:   cfg.sensor_present      = data[0];
				CFG_BUTTON_PRES:   cfg.button_present      = data[0];
				CFG_DEBOUNCE:      cfg.debounce_window_ms  = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [DUR_W:0] tone_on(logic [1:0] sel, logic [1:0] s);
			case (sel)
				TUNE_SINGLE:  return {1'b0, single_on_ms};
				TUNE_SUCCESS: return (s < 2'd2) ? 17'd120 : 17'd0;
				TUNE_DENIED:  return (s < 2'd3) ? 17'd90 : 17'd0;
				default:      return (s == 2'd0) ? 17'd400 : 17'd0;
			endcase
		endfunction

		function logic [DUR_W:0] tone_off(logic [1:0] sel, logic [1:0] s);
			case (sel)
				TUNE_SUCCESS: return (s == 2'd0) ? 17'd80 : 17'd0;
				TUNE_DENIED:  return (s < 2'd2) ? 17'd70 : 17'd0;
				default:      return 17'd0;
			endcase
		endfunction

		function logic [1:0] tune_steps(logic [1:0] sel);
			case (sel)
				TUNE_SUCCESS: return 2'd2;
				TUNE_DENIED:  return 2'd3;
				default:      return 2'd1;
			endcase
		endfunction

		function void open_relay(logic [DUR_W-1:0] d);
			logic [DUR_W-1:0] t;
			t = (d == '0) ? cfg.relay_default_ms : d;
			if (t != '0) begin
				unlocked   = 1'b1;
				relay_left = t;
			end
		endfunction

		function void start_tune(logic [1:0] sel);
			tune_sel     = sel;
			tune_step    = 2'd0;
			step_elapsed = '0;
			playing      = 1'b1;
			buzzing      = 1'b1;
		endfunction

		// one millisecond: relay, tune, LED, then button
		function void advance_ms(logic pressed);
			logic [1:0]     s;
			logic [DUR_W:0] on_ms;
			logic [DUR_W:0] off_ms;
			logic [DUR_W+1:0] span;
			if (unlocked) begin
				if (relay_left != '0)
					relay_left = relay_left - 1'b1;
				if (relay_left == '0)
					unlocked = 1'b0;
			end
			if (playing) begin
				s      = (tune_step == 2'd3) ? 2'd0 : tune_step;
				on_ms  = tone_on(tune_sel, s);
				off_ms = tone_off(tune_sel, s);
				span   = {1'b0, on_ms} + {1'b0, off_ms};
				if (step_elapsed != '1)
					step_elapsed = step_elapsed + 1'b1;
				buzzing = step_elapsed < on_ms;
				if ({1'b0, step_elapsed} >= span) begin
					tune_step = tune_step + 2'd1;
					if (tune_step >= tune_steps(tune_sel)) begin
						playing   = 1'b0;
						tune_step = 2'd0;
						tune_sel  = TUNE_SINGLE;
						buzzing   = 1'b0;
					end else begin
						step_elapsed = '0;
					end
				end
			end
			if (led_lit) begin
				if (led_left != '0)
					led_left = led_left - 1'b1;
				if (led_left == '0)
					led_lit = 1'b0;
			end
			if (cfg.button_present) begin
				if (pressed != btn_last) begin
					btn_last      = pressed;
					btn_stable_ms = '0;
				end else begin
					if (btn_stable_ms != '1)
						btn_stable_ms = btn_stable_ms + 1'b1;
					if (pressed && btn_stable_ms >= cfg.debounce_window_ms) begin
						if (!btn_latched) begin
							btn_latched = 1'b1;
							open_relay(cfg.relay_default_ms);
							start_tune(TUNE_OPEN);
						end
					end else if (!pressed) begin
						btn_latched = 1'b0;
					end
				end
			end
		endfunction

		function void note_request(door_req_t r);
			door_out_t want;
			case (r.req_type)
				REQ_TICK:  advance_ms(r.button_pressed);
				REQ_OPEN:  open_relay(r.duration_ms);
				REQ_CLOSE: begin
					unlocked   = 1'b0;
					relay_left = '0;
				end
				REQ_BEEP: begin
					single_on_ms = (r.duration_ms != '0) ? r.duration_ms : 16'd200;
					start_tune(TUNE_SINGLE);
				end
				REQ_SUCCESS: start_tune(TUNE_SUCCESS);
				REQ_DENIED:  start_tune(TUNE_DENIED);
				REQ_OPENMEL: start_tune(TUNE_OPEN);
				default: begin
					led_lit  = 1'b1;
					led_left = r.duration_ms;
				end
			endcase
			want.relay_level   = unlocked ^ cfg.relay_polarity_low;
			want.buzzer_level  = buzzing;
			want.led_level     = led_lit;
			want.door_unlocked = unlocked;
			want.door_physically_open = cfg.sensor_present &
				(cfg.sensor_polarity_low ? !r.sensor_level : r.sensor_level);
			want.melody_busy   = playing;
			expected_q.push_back(want);
		endfunction

		function void cmp_bit(string field, logic want, logic got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0b, actual %0b",
					$time, field, want, got);
			end
		endfunction

		function void check_result(door_out_t got);
			door_out_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending: expected none, actual %b",
					$time, got);
				return;
			end
			want = expected_q.pop_front();
			cmp_bit("relay_level", want.relay_level, got.relay_level);
			cmp_bit("buzzer_level", want.buzzer_level, got.buzzer_level);
			cmp_bit("led_level", want.led_level, got.led_level);
			cmp_bit("door_unlocked", want.door_unlocked, got.door_unlocked);
			cmp_bit("door_physically_open", want.door_physically_open,
				got.door_physically_open);
			cmp_bit("melody_busy", want.melody_busy, got.melody_busy);
		endfunction
	endclass

endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the door relay, buzzer and LED timer unit. Directed requests
// cover zero and full durations and every command; random phases under
// several register settings mix millisecond ticks, debounced button presses
// with bounce, and commands, with random gaps and result stalls. A final
// phase holds the button under the widest debounce window.
// ----------------------------------------------------------------------------
module tb_top;
	import drblt_pkg::*;
	import drblt_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT       = 18;
	localparam int HOLD_TICKS     = 40;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CDATA_W-1:0] cfg_wdata;
	logic               quiet;
	logic               btn_level;
	int                 btn_left;
	int                 stuck_cycles;
	door_timer_scoreboard sb;

	drblt_req_if req_if();
	drblt_res_if res_if();

	door_relay_buzzer_led_timer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.res       (res_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		res_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result({res_if.relay_level, res_if.buzzer_level, res_if.led_level,
				res_if.door_unlocked, res_if.door_physically_open, res_if.melody_busy});
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, stuck_cycles);
			$display("** door_relay_buzzer_led_timer_unit: FAILED **");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic door_req_t pack_req(logic [REQ_W-1:0] kind, logic [DUR_W-1:0] dur,
			logic pressed, logic level);
		door_req_t r;
		r.req_type       = kind;
		r.duration_ms    = dur;
		r.button_pressed = pressed;
		r.sensor_level   = level;
		return r;
	endfunction

	task automatic send_req(input door_req_t r);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid          <= 1'b1;
		req_if.req_type       <= r.req_type;
		req_if.duration_ms    <= r.duration_ms;
		req_if.button_pressed <= r.button_pressed;
		req_if.sensor_level   <= r.sensor_level;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic load_config(input cfg_t c);
		put_reg(CFG_RELAY_DEFAULT, c.relay_default_ms);
		put_reg(CFG_RELAY_POL, {15'd0, c.relay_polarity_low});
		put_reg(CFG_SENSOR_POL, {15'd0, c.sensor_polarity_low});
		put_reg(CFG_SENSOR_PRES, {15'd0, c.sensor_present});
		put_reg(CFG_BUTTON_PRES, {15'd0, c.button_present});
		put_reg(CFG_DEBOUNCE, c.debounce_window_ms);
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t phase_config(int k);
		cfg_t c;
		c.relay_polarity_low  = 1'($urandom_range(0, 1));
		c.sensor_polarity_low = 1'($urandom_range(0, 1));
		c.sensor_present      = ($urandom_range(0, 3) != 0);
		c.button_present      = 1'b1;
		c.relay_default_ms    = DUR_W'($urandom_range(1, 60));
		c.debounce_window_ms  = DUR_W'($urandom_range(0, 12));
		case (k)
			1: begin
				c = '0;
				c.relay_polarity_low = 1'b1;
				c.button_present     = 1'b1;
			end
			2: begin
				c = '1;
				c.relay_polarity_low = 1'b0;
				c.button_present     = 1'b0;
			end
			4: begin
				c.relay_default_ms   = DUR_W'($urandom_range(100, 400));
				c.debounce_window_ms = 16'd50;
			end
			default: ;
		endcase
		return c;
	endfunction

	// exit button: qualified presses, releases and short bounces
	task automatic button_tick(output logic pressed);
		int pick;
		int win;
		win = int'(sb.cfg.debounce_window_ms);
		if (btn_left == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				btn_level = 1'b1;
				btn_left  = (win < 64) ? win + $urandom_range(1, 12) : $urandom_range(1, 30);
			end else if (pick < 8) begin
				btn_level = 1'b0;
				btn_left  = $urandom_range(1, 20);
			end else begin
				btn_level = ~btn_level;
				btn_left  = $urandom_range(1, 2);
			end
		end
		btn_left--;
		pressed = btn_level;
	endtask

	function automatic logic [DUR_W-1:0] cmd_duration();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		else if (pick < 3)
			return DUR_W'($urandom_range(0, 65535));
		return DUR_W'($urandom_range(1, 80));
	endfunction

	task automatic random_items(input int n, input int pause_at);
		door_req_t r;
		logic      p;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				settle();
			if ($urandom_range(0, 99) < 10) begin
				r.req_type       = REQ_W'($urandom_range(REQ_OPEN, REQ_BLINK));
				r.duration_ms    = cmd_duration();
				r.button_pressed = 1'($urandom_range(0, 1));
			end else begin
				button_tick(p);
				r.req_type       = REQ_TICK;
				r.duration_ms    = DUR_W'($urandom_range(0, 65535));
				r.button_pressed = p;
			end
			r.sensor_level = 1'($urandom_range(0, 1));
			send_req(r);
		end
	endtask

	initial begin : main
		cfg_t c;
		sb = new();
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_RELAY_DEFAULT;
		cfg_wdata             = '0;
		req_if.valid          = 1'b0;
		req_if.req_type       = REQ_TICK;
		req_if.duration_ms    = '0;
		req_if.button_pressed = 1'b0;
		req_if.sensor_level   = 1'b0;
		res_if.ready          = 1'b0;
		quiet                 = 1'b0;
		btn_level             = 1'b0;
		btn_left              = 0;
		stuck_cycles          = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(pack_req(REQ_TICK, 16'hFFFF, 1'b0, 1'b0));
		send_req(pack_req(REQ_OPEN, 16'd0, 1'b0, 1'b1));
		send_req(pack_req(REQ_OPEN, 16'hFFFF, 1'b0, 1'b0));
		send_req(pack_req(REQ_CLOSE, 16'd0, 1'b1, 1'b1));
		send_req(pack_req(REQ_OPEN, 16'd1, 1'b0, 1'b0));
		send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b1));
		send_req(pack_req(REQ_BEEP, 16'd0, 1'b0, 1'b0));
		send_req(pack_req(REQ_BEEP, 16'hFFFF, 1'b0, 1'b1));
		send_req(pack_req(REQ_BEEP, 16'd1, 1'b0, 1'b0));
		send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b1));
		send_req(pack_req(REQ_SUCCESS, 16'hFFFF, 1'b0, 1'b0));
		send_req(pack_req(REQ_DENIED, 16'd0, 1'b0, 1'b1));
		send_req(pack_req(REQ_OPENMEL, 16'd0, 1'b0, 1'b0));
		send_req(pack_req(REQ_BLINK, 16'd0, 1'b0, 1'b1));
		send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b0));
		send_req(pack_req(REQ_BLINK, 16'hFFFF, 1'b0, 1'b1));
		send_req(pack_req(REQ_BLINK, 16'd1, 1'b0, 1'b0));
		send_req(pack_req(REQ_TICK, 16'd0, 1'b1, 1'b1));
		random_items(250, -1);

		for (int k = 1; k <= 5; k++) begin
			settle();
			c = phase_config(k);
			load_config(c);
			quiet <= (k == 3);
			if (k == 1) begin
				// zero default time: open is a no-op, a press plays the tune only
				send_req(pack_req(REQ_OPEN, 16'd0, 1'b0, 1'b0));
				send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b1));
				send_req(pack_req(REQ_TICK, 16'd0, 1'b1, 1'b0));
				send_req(pack_req(REQ_TICK, 16'd0, 1'b1, 1'b1));
				send_req(pack_req(REQ_TICK, 16'd0, 1'b1, 1'b0));
			end
			case (k)
				1: random_items(230, -1);
				2: random_items(200, -1);
				3: random_items(250, -1);
				4: random_items(300, 150);
				default: random_items(260, -1);
			endcase
		end

		// widest window, button held
		settle();
		quiet <= 1'b0;
		c = '0;
		c.relay_default_ms    = 16'd2;
		c.sensor_polarity_low = 1'b1;
		c.sensor_present      = 1'b1;
		c.button_present      = 1'b1;
		c.debounce_window_ms  = 16'hFFFF;
		load_config(c);
		send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b0));
		send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b1));
		for (int i = 0; i < HOLD_TICKS; i++)
			send_req(pack_req(REQ_TICK, DUR_W'($urandom_range(0, 65535)), 1'b1,
				1'($urandom_range(0, 1))));
		send_req(pack_req(REQ_TICK, 16'd0, 1'b0, 1'b0));

		settle();
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d results still expected: expected 0, actual %0d",
				$time, sb.pending(), sb.pending());
		end
		if (sb.errors == 0)
			$display("** door_relay_buzzer_led_timer_unit: PASSED **");
		else
			$display("** door_relay_buzzer_led_timer_unit: FAILED **");
		$finish;
	end

endmodule
